[src/tdpt_pkg.sv]
// Shared types and constants for the trial division prime test core.
// No dependencies; imported by every module of the block.
`default_nettype none

package tdpt_pkg;

  localparam int unsigned ValueWidthDefault = 32;
  localparam int unsigned SmallestPrime     = 2;
  localparam int unsigned FirstOddDivisor   = 3;
  localparam int unsigned DivisorStep       = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_REPORT
  } tdpt_state_e;

  // Status of the serial remainder unit, valid while done is high.
  typedef struct packed {
    logic done;
    logic rem_zero;
    logic past_bound;
  } rem_stat_t;

endpackage : tdpt_pkg

`default_nettype wire

[src/trial_division_prime_test_core.sv]
// Negative, zero, one, two and even values are settled without dividing; odd values
// are divided by odd trial divisors in turn until one divides or the bound is passed.
// One bit-serial remainder unit is shared by all trial divisors, which are tried one
// after another. One item at a time; busy is high through the result beat.
// The result beat lasts one cycle and cannot be stalled. Reset is asynchronous,
// active low, and returns the core to idle; no state is kept between items.
`default_nettype none

module trial_division_prime_test_core
  import tdpt_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = ValueWidthDefault
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [VALUE_WIDTH-1:0] candidate_value_i,
  output logic                        done_o,
  output logic                        is_prime_o
);

  tdpt_state_e            state_q, state_d;
  logic [VALUE_WIDTH-1:0] value_q, value_d;
  logic [VALUE_WIDTH-1:0] divisor_q, divisor_d;
  logic                   prime_q, prime_d;
  logic                   accept;
  logic                   quick_out;
  logic                   div_start;
  logic [VALUE_WIDTH-1:0] dividend;
  rem_stat_t              rem_stat;

  assign accept = start && !busy;

  // Negative, zero, one and even values are settled without dividing.
  assign quick_out = candidate_value_i[VALUE_WIDTH-1]
                  || (candidate_value_i[VALUE_WIDTH-1:1] == '0)
                  || !candidate_value_i[0];

  assign dividend = (state_q == ST_IDLE) ? candidate_value_i : value_q;

  tdpt_rem_unit #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_rem_unit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor_q),
    .stat_o     (rem_stat)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = quick_out ? ST_REPORT : ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (rem_stat.done && (rem_stat.past_bound || rem_stat.rem_zero)) begin
          state_d = ST_REPORT;
        end
      end
      ST_REPORT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    done_o    = 1'b0;
    div_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy      = 1'b0;
        div_start = accept && !quick_out;
      end
      ST_DIVIDE: begin
        div_start = rem_stat.done && !rem_stat.past_bound && !rem_stat.rem_zero;
      end
      ST_REPORT: begin
        done_o = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_comb begin
    value_d   = value_q;
    divisor_d = divisor_q;
    prime_d   = prime_q;
    if (accept) begin
      value_d   = candidate_value_i;
      divisor_d = VALUE_WIDTH'(FirstOddDivisor);
      prime_d   = (candidate_value_i == VALUE_WIDTH'(SmallestPrime));
    end else if (state_q == ST_DIVIDE && rem_stat.done) begin
      // The bound is tested before the remainder, as d > n / d means no divisor is left.
      if (rem_stat.past_bound) begin
        prime_d = 1'b1;
      end else if (rem_stat.rem_zero) begin
        prime_d = 1'b0;
      end else begin
        divisor_d = divisor_q + VALUE_WIDTH'(DivisorStep);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q   <= value_d;
    divisor_q <= divisor_d;
    prime_q   <= prime_d;
  end

  assign is_prime_o = prime_q;

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("core did not go busy after accepting a beat");

  a_prime_is_odd_or_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && is_prime_o) |->
      (value_q[0] || value_q == VALUE_WIDTH'(SmallestPrime)))
    else $error("even value other than two reported prime");

  a_divisor_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVIDE) |-> divisor_q[0])
    else $error("trial divisor is even");

endmodule : trial_division_prime_test_core

`default_nettype wire

[src/tdpt_rem_unit.sv]
// Bit-serial restoring divider: one dividend bit per cycle, quotient and remainder.
// Depends on tdpt_pkg for the status struct.
`default_nettype none

module tdpt_rem_unit
  import tdpt_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = ValueWidthDefault
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [VALUE_WIDTH-1:0] dividend_i,
  input  wire logic [VALUE_WIDTH-1:0] divisor_i,
  output rem_stat_t                   stat_o
);

  localparam int unsigned CntWidth = $clog2(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] rem_q, rem_d;
  logic [VALUE_WIDTH-1:0] quo_q;
  logic [VALUE_WIDTH-1:0] trial_rem;
  logic                   quo_bit;
  logic [CntWidth-1:0]    cnt_q;
  logic                   run_q;
  logic                   done_q;

  // The divisor never exceeds the square root of the value plus two, so the
  // shifted remainder always fits the value width.
  assign trial_rem = {rem_q[VALUE_WIDTH-2:0], quo_q[VALUE_WIDTH-1]};
  assign quo_bit   = (trial_rem >= divisor_i);
  assign rem_d     = quo_bit ? (trial_rem - divisor_i) : trial_rem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntWidth'(VALUE_WIDTH - 1);
    end else if (run_q) begin
      if (cnt_q == '0) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - CntWidth'(1);
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[VALUE_WIDTH-2:0], quo_bit};
    end
  end

  assign stat_o.done       = done_q;
  assign stat_o.rem_zero   = (rem_q == '0);
  assign stat_o.past_bound = (divisor_i > quo_q);

  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !run_q)
    else $error("remainder unit reports done while still shifting");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("remainder unit done held for more than one cycle");

  a_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q && !start_i && cnt_q == '0) |=> done_q)
    else $error("remainder unit missed done after last step");

endmodule : tdpt_rem_unit

`default_nettype wire
